/* sv/amu_pkg.sv */
// amu_pkg: shared types and constants for the atomic 256-bit memory unit.
// No dependencies; imported by every amu module.
package amu_pkg;

  localparam int ENTRIES = 16;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WORD_W  = 256;
  localparam int SLICE_W = 64;
  localparam int IDX_W   = 4;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_XCHG = 2'd2,
    ACT_CAS  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } bk_st_t;

  typedef struct packed {
    act_t               act;
    logic               hit;
    logic [ADDR_W-1:0]  addr;
    logic [WORD_W-1:0]  operand;
    logic [WORD_W-1:0]  expv;
  } req_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

endpackage

/* sv/amu_front.sv */
// amu_front: accepts request beats, checks the index range and packs a queue entry.
// Depends on amu_pkg.
module amu_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_action,
  input  logic [3:0]             in_entry_index,
  input  logic [63:0]            in_operand_w0,
  input  logic [63:0]            in_operand_w1,
  input  logic [63:0]            in_operand_w2,
  input  logic [63:0]            in_operand_w3,
  input  logic [63:0]            in_expect_w0,
  input  logic [63:0]            in_expect_w1,
  input  logic [63:0]            in_expect_w2,
  input  logic [63:0]            in_expect_w3,
  input  amu_pkg::bk_status_t    bk_status,
  output logic                   push_valid,
  input  logic                   push_ready,
  output amu_pkg::req_t          push_data
);
  import amu_pkg::*;

  logic hit;

  assign hit = (32'(in_entry_index) < ENTRIES);

  always_comb begin
    push_data.act     = act_t'(in_action);
    push_data.hit     = hit;
    push_data.addr    = ADDR_W'(in_entry_index);
    push_data.operand = {in_operand_w3, in_operand_w2, in_operand_w1, in_operand_w0};
    push_data.expv    = {in_expect_w3, in_expect_w2, in_expect_w1, in_expect_w0};
  end

  assign in_ready   = push_ready && !bk_status.clearing;
  assign push_valid = in_valid && in_ready;

  ap_no_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.clearing |-> !push_valid)
    else $error("request pushed during table clear");

endmodule

/* sv/amu_fifo.sv */
// amu_fifo: short request queue between front and back.
// Depends on amu_pkg.
module amu_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  amu_pkg::req_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output amu_pkg::req_t  pop_data
);
  import amu_pkg::*;

  req_t               q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == Q_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == Q_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

  ap_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= Q_DEPTH)
    else $error("queue count overflow");

endmodule

/* sv/amu_back.sv */
// amu_back: entry table, clear sweep, atomic execute and result register.
// Depends on amu_pkg.
module amu_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  amu_pkg::req_t          q_item,
  output amu_pkg::bk_status_t    bk_status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [255:0]           out_prior,
  output logic                   out_swap
);
  import amu_pkg::*;

  logic [WORD_W-1:0]  mem [ENTRIES];
  logic [WORD_W-1:0]  rd_r;
  req_t               cur_r;

  bk_st_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_prior_r, out_prior_nxt;
  logic               out_swap_r, out_swap_nxt;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [WORD_W-1:0]  mem_wd;
  logic [WORD_W-1:0]  prior;
  logic [WORD_W-1:0]  sum;
  logic               match;
  logic               slot_free;

  assign prior     = cur_r.hit ? rd_r : '0;
  assign sum       = prior + cur_r.operand;
  assign match     = (prior == cur_r.expv);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_prior_nxt = out_prior_r;
    out_swap_nxt  = out_swap_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = cur_r.addr;
    mem_wd        = cur_r.operand;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = '0;
        if (32'(clr_cnt_r) == ENTRIES - 1) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          case (cur_r.act)
            ACT_ADD: begin
              mem_we = cur_r.hit;
              mem_wd = sum;
            end
            ACT_XCHG: mem_we = cur_r.hit;
            ACT_CAS:  mem_we = cur_r.hit && match;
            default:  mem_we = 1'b0;
          endcase
          out_valid_nxt = 1'b1;
          out_prior_nxt = prior;
          out_swap_nxt  = cur_r.hit && match && (cur_r.act == ACT_CAS);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_prior_r <= out_prior_nxt;
    out_swap_r  <= out_swap_nxt;
    if (q_pop) begin
      cur_r <= q_item;
      rd_r  <= mem[q_item.addr];
    end
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  assign bk_status.clearing = (state_r == ST_CLEAR);
  assign out_valid          = out_valid_r;
  assign out_prior          = out_prior_r;
  assign out_swap           = out_swap_r;

  ap_miss_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && !cur_r.hit) |-> !mem_we)
    else $error("table written for out-of-range index");

  ap_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result raised outside execute");

  ap_swap_only_cas: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && slot_free && cur_r.act != ACT_CAS) |=> !out_swap_r)
    else $error("swap flag set for non-CAS action");

  ap_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_prior_r)))
    else $error("stalled result lost");

endmodule

/* sv/atomic_256bit_memory_unit_core.sv */
// atomic_256bit_memory_unit_core: top level of the atomic 256-bit memory unit.
// Depends on amu_pkg, amu_front, amu_fifo, amu_back.
//
// Channel | Ports                              | Beat
// input   | in_valid / in_ready, in_*          | one atomic request
// result  | out_valid / out_ready, out_*       | prior entry value and swap flag
//
// The back unit handles each request as a registered table read, then an
// execute and write back; it pops no new request until the last one has executed.
// An accepted request passes the queue, the table read and the result register.
// After reset a clearing pass zeroes the table, one entry per cycle over all
// ENTRIES (16) entries; in_ready stays low during it.
// A 2-entry queue decouples accept from execute; a stalled result holds in its
// output register while the queue keeps filling.
module atomic_256bit_memory_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_entry_index,
  input  logic [63:0] in_operand_w0,
  input  logic [63:0] in_operand_w1,
  input  logic [63:0] in_operand_w2,
  input  logic [63:0] in_operand_w3,
  input  logic [63:0] in_expect_w0,
  input  logic [63:0] in_expect_w1,
  input  logic [63:0] in_expect_w2,
  input  logic [63:0] in_expect_w3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_prior_w0,
  output logic [63:0] out_prior_w1,
  output logic [63:0] out_prior_w2,
  output logic [63:0] out_prior_w3,
  output logic        out_swap_done
);
  import amu_pkg::*;

  bk_status_t   bk_status;
  logic         push_valid, push_ready;
  req_t         push_data;
  logic         q_valid, q_pop;
  req_t         q_item;
  logic [255:0] out_prior;

  amu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_operand_w0  (in_operand_w0),
    .in_operand_w1  (in_operand_w1),
    .in_operand_w2  (in_operand_w2),
    .in_operand_w3  (in_operand_w3),
    .in_expect_w0   (in_expect_w0),
    .in_expect_w1   (in_expect_w1),
    .in_expect_w2   (in_expect_w2),
    .in_expect_w3   (in_expect_w3),
    .bk_status      (bk_status),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  amu_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_item)
  );

  amu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .bk_status (bk_status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_prior (out_prior),
    .out_swap  (out_swap_done)
  );

  assign out_prior_w0 = out_prior[SLICE_W-1:0];
  assign out_prior_w1 = out_prior[2*SLICE_W-1:SLICE_W];
  assign out_prior_w2 = out_prior[3*SLICE_W-1:2*SLICE_W];
  assign out_prior_w3 = out_prior[4*SLICE_W-1:3*SLICE_W];

endmodule

/* dv/amu_result_checker.sv */
// amu_result_checker: watches both channels of the atomic 256-bit memory unit,
// predicts each result from its own copy of the table and compares it.
// Depends on amu_pkg.
`timescale 1ns / 1ps

module amu_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_entry_index,
  input  logic [63:0] in_operand_w0,
  input  logic [63:0] in_operand_w1,
  input  logic [63:0] in_operand_w2,
  input  logic [63:0] in_operand_w3,
  input  logic [63:0] in_expect_w0,
  input  logic [63:0] in_expect_w1,
  input  logic [63:0] in_expect_w2,
  input  logic [63:0] in_expect_w3,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_prior_w0,
  input  logic [63:0] out_prior_w1,
  input  logic [63:0] out_prior_w2,
  input  logic [63:0] out_prior_w3,
  input  logic        out_swap_done,
  output int          fail_count,
  output int          pending
);
  import amu_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] prior;
    logic              swap_done;
  } atomic_result_t;

  logic [WORD_W-1:0] entry_table [ENTRIES];
  atomic_result_t    prior_value_q [$];

  function automatic atomic_result_t serve_request(act_t act, logic [IDX_W-1:0] idx,
                                                   logic [WORD_W-1:0] opnd,
                                                   logic [WORD_W-1:0] expv);
    atomic_result_t res;
    res = '0;
    if (idx < ENTRIES) begin
      res.prior = entry_table[idx];
      case (act)
        ACT_ADD: begin
          entry_table[idx] = res.prior + opnd;
        end
        ACT_XCHG: begin
          entry_table[idx] = opnd;
        end
        ACT_CAS: begin
          if (res.prior == expv) begin
            entry_table[idx] = opnd;
            res.swap_done = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    atomic_result_t want;
    if (!rst_n) begin
      foreach (entry_table[i]) entry_table[i] = '0;
      prior_value_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (prior_value_q.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_count++;
        end else begin
          want = prior_value_q.pop_front();
          if (out_prior_w0 !== want.prior[63:0]) begin
            $error("prior_w0: expected %h, got %h", want.prior[63:0], out_prior_w0);
            fail_count++;
          end
          if (out_prior_w1 !== want.prior[127:64]) begin
            $error("prior_w1: expected %h, got %h", want.prior[127:64], out_prior_w1);
            fail_count++;
          end
          if (out_prior_w2 !== want.prior[191:128]) begin
            $error("prior_w2: expected %h, got %h", want.prior[191:128], out_prior_w2);
            fail_count++;
          end
          if (out_prior_w3 !== want.prior[255:192]) begin
            $error("prior_w3: expected %h, got %h", want.prior[255:192], out_prior_w3);
            fail_count++;
          end
          if (out_swap_done !== want.swap_done) begin
            $error("swap_done: expected %b, got %b", want.swap_done, out_swap_done);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        prior_value_q.push_back(serve_request(
          act_t'(in_action), in_entry_index,
          {in_operand_w3, in_operand_w2, in_operand_w1, in_operand_w0},
          {in_expect_w3, in_expect_w2, in_expect_w1, in_expect_w0}));
      end
    end
    pending = prior_value_q.size();
  end

endmodule

/* dv/atomic_256bit_memory_unit_core_tb.sv */
// atomic_256bit_memory_unit_core_tb: drives requests into the atomic 256-bit
// memory unit and gives the verdict. Depends on amu_pkg, the unit and
// amu_result_checker.
`timescale 1ns / 1ps

module atomic_256bit_memory_unit_core_tb;
  import amu_pkg::*;

  localparam int NUM_ITEMS    = 1800;
  localparam int WATCHDOG_MAX = 3000;
  localparam int HOLD_CYCLES  = 120;
  localparam int HOLD_AT      = 700;
  localparam int BURST_LO     = 1000;
  localparam int BURST_HI     = 1300;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [3:0]  in_entry_index;
  logic [63:0] in_operand_w0;
  logic [63:0] in_operand_w1;
  logic [63:0] in_operand_w2;
  logic [63:0] in_operand_w3;
  logic [63:0] in_expect_w0;
  logic [63:0] in_expect_w1;
  logic [63:0] in_expect_w2;
  logic [63:0] in_expect_w3;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_prior_w0;
  logic [63:0] out_prior_w1;
  logic [63:0] out_prior_w2;
  logic [63:0] out_prior_w3;
  logic        out_swap_done;

  int fail_count;
  int pending;
  int sent_count;
  int quiet_cycles;
  int hold_left;
  bit hold_done;
  logic [WORD_W-1:0] value_pool [8];

  atomic_256bit_memory_unit_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_operand_w0  (in_operand_w0),
    .in_operand_w1  (in_operand_w1),
    .in_operand_w2  (in_operand_w2),
    .in_operand_w3  (in_operand_w3),
    .in_expect_w0   (in_expect_w0),
    .in_expect_w1   (in_expect_w1),
    .in_expect_w2   (in_expect_w2),
    .in_expect_w3   (in_expect_w3),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_prior_w0   (out_prior_w0),
    .out_prior_w1   (out_prior_w1),
    .out_prior_w2   (out_prior_w2),
    .out_prior_w3   (out_prior_w3),
    .out_swap_done  (out_swap_done)
  );

  amu_result_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_operand_w0  (in_operand_w0),
    .in_operand_w1  (in_operand_w1),
    .in_operand_w2  (in_operand_w2),
    .in_operand_w3  (in_operand_w3),
    .in_expect_w0   (in_expect_w0),
    .in_expect_w1   (in_expect_w1),
    .in_expect_w2   (in_expect_w2),
    .in_expect_w3   (in_expect_w3),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_prior_w0   (out_prior_w0),
    .out_prior_w1   (out_prior_w1),
    .out_prior_w2   (out_prior_w2),
    .out_prior_w3   (out_prior_w3),
    .out_swap_done  (out_swap_done),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    for (int s = 0; s < 4; s++) begin
      w[s*SLICE_W +: SLICE_W] = {$urandom, $urandom};
    end
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    if ($urandom_range(0, 1) == 0) begin
      w = value_pool[3'($urandom_range(0, 7))];
    end else begin
      w = random_word();
    end
    return w;
  endfunction

  // one request beat; entered and left at a falling edge
  task automatic issue(input act_t act, input logic [3:0] idx,
                       input logic [WORD_W-1:0] opnd, input logic [WORD_W-1:0] expv);
    while ((sent_count < BURST_LO || sent_count >= BURST_HI) &&
           $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_entry_index <= idx;
    in_operand_w0  <= opnd[63:0];
    in_operand_w1  <= opnd[127:64];
    in_operand_w2  <= opnd[191:128];
    in_operand_w3  <= opnd[255:192];
    in_expect_w0   <= expv[63:0];
    in_expect_w1   <= expv[127:64];
    in_expect_w2   <= expv[191:128];
    in_expect_w3   <= expv[255:192];
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  // result side: random stalls, one long hold-off, and a stall-free burst
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (sent_count >= BURST_LO && sent_count < BURST_HI) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [WORD_W-1:0] known;
    logic [WORD_W-1:0] nxt;
    logic [WORD_W-1:0] opnd;
    logic [WORD_W-1:0] pattern_a;
    logic [3:0]        idx;
    int                seq_len;
    int                pick;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_LOAD;
    in_entry_index = '0;
    in_operand_w0  = '0;
    in_operand_w1  = '0;
    in_operand_w2  = '0;
    in_operand_w3  = '0;
    in_expect_w0   = '0;
    in_expect_w1   = '0;
    in_expect_w2   = '0;
    in_expect_w3   = '0;
    sent_count     = 0;

    value_pool[0] = '0;
    value_pool[1] = ALL_ONES;
    value_pool[2] = 256'd1;
    value_pool[3] = {192'd0, 64'hFFFF_FFFF_FFFF_FFFF};
    for (int i = 4; i < 8; i++) value_pool[i] = random_word();
    pattern_a = random_word();

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed
    issue(ACT_LOAD, 4'd0, ALL_ONES, ALL_ONES);
    issue(ACT_XCHG, 4'd0, ALL_ONES, '0);
    issue(ACT_ADD,  4'd0, 256'd1, '0);
    issue(ACT_LOAD, 4'd0, '0, '0);
    issue(ACT_XCHG, 4'd1, {192'd0, 64'hFFFF_FFFF_FFFF_FFFF}, '0);
    issue(ACT_ADD,  4'd1, 256'd1, '0);
    issue(ACT_ADD,  4'd1, {64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 128'd0}, '0);
    issue(ACT_XCHG, 4'd2, ALL_ONES, '0);
    issue(ACT_ADD,  4'd2, ALL_ONES, '0);
    issue(ACT_CAS,  4'd3, pattern_a, '0);
    issue(ACT_CAS,  4'd3, ALL_ONES, '0);
    issue(ACT_CAS,  4'd3, ALL_ONES, pattern_a ^ {64'd1, 192'd0});
    issue(ACT_CAS,  4'd3, ALL_ONES, pattern_a);
    issue(ACT_LOAD, 4'd3, '0, ALL_ONES);
    issue(ACT_ADD,  4'd4, ALL_ONES, '0);
    issue(ACT_ADD,  4'd4, ALL_ONES, '0);
    issue(ACT_ADD,  4'd4, 256'd2, '0);
    issue(ACT_XCHG, 4'd15, pattern_a, '0);
    issue(ACT_CAS,  4'd15, '0, pattern_a);
    issue(ACT_LOAD, 4'd15, ALL_ONES, ALL_ONES);

    // random: well-formed chains (exchange, then compare-and-swap, add or load) plus loose requests
    while (sent_count < NUM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        idx     = 4'($urandom_range(0, 15));
        known   = pick_word();
        seq_len = $urandom_range(2, 7);
        issue(ACT_XCHG, idx, known, pick_word());
        for (int k = 0; k < seq_len; k++) begin
          pick = $urandom_range(0, 99);
          opnd = pick_word();
          if (pick < 55) begin
            nxt = known;
            if ($urandom_range(0, 9) == 0) nxt[8'($urandom_range(0, WORD_W-1))] ^= 1'b1;
            issue(ACT_CAS, idx, opnd, nxt);
            if (nxt == known) known = opnd;
          end else if (pick < 80) begin
            issue(ACT_ADD, idx, opnd, pick_word());
            known = known + opnd;
          end else begin
            issue(ACT_LOAD, idx, opnd, pick_word());
          end
        end
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          idx = 4'($urandom_range(0, 3));
        end else begin
          idx = 4'($urandom_range(0, 15));
        end
        issue(act_t'(2'($urandom_range(0, 3))), idx, pick_word(), pick_word());
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
